// File: rtl/imu_offset_calibrator_unit_assert.svh
// assertion macros for the imu offset calibrator
`ifndef IMU_OFFSET_CALIBRATOR_UNIT_ASSERT_SVH
`define IMU_OFFSET_CALIBRATOR_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define IOC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define IOC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/imu_oc_pkg.sv
// shared constants and types for the imu offset calibrator
`default_nettype none
package imu_oc_pkg;

  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned NUM_AXES   = 6;
  localparam int unsigned AXIS_W     = $clog2(NUM_AXES);
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned VAL_W      = 16;
  localparam int unsigned ACC_OFF_W  = 15;
  localparam int unsigned SPW_W      = 16;
  localparam int unsigned TOL_W      = 8;
  localparam int unsigned GRAV_W     = 15;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned WIN_W      = (COUNT_BITS > SPW_W) ? COUNT_BITS : SPW_W;
  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned OUT_DATA_W = 96;

  localparam logic [CFG_IDX_W-1:0] REG_SPW      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ACC_TOL  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_GYR_TOL  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY  = CFG_IDX_W'(3);

  localparam logic [SPW_W-1:0]  SPW_RST      = SPW_W'(1000);
  localparam logic [TOL_W-1:0]  ACC_TOL_RST  = TOL_W'(8);
  localparam logic [TOL_W-1:0]  GYR_TOL_RST  = TOL_W'(1);
  localparam logic [GRAV_W-1:0] GRAVITY_RST  = GRAV_W'(2048);

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam logic [AXIS_W-1:0] AXIS_AZ   = AXIS_W'(2);
  localparam logic [AXIS_W-1:0] AXIS_GX   = AXIS_W'(3);
  localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(NUM_AXES - 1);

  typedef logic [VAL_W-1:0] val_t;

  // handshake between the sequencer and the divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

// File: rtl/imu_oc_div.sv
// bit-serial signed by unsigned divider, truncating, low half of quotient out
`default_nettype none
module imu_oc_div
  import imu_oc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [SUM_W-1:0]      dividend_i,
  input  wire logic [COUNT_BITS-1:0] divisor_i,
  output div_stat_t                  stat_o,
  output val_t                       quot_o
);

  localparam int unsigned STEP_W = $clog2(SUM_W);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic                  neg_q, neg_d;
  logic [SUM_W-1:0]      quot_q, quot_d;
  logic [COUNT_BITS:0]   rem_q, rem_d;
  logic [COUNT_BITS-1:0] div_q, div_d;
  logic [COUNT_BITS:0]   rem_sh;
  logic                  fits;

  assign rem_sh = {rem_q[COUNT_BITS-1:0], quot_q[SUM_W-1]};
  assign fits   = rem_sh >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    neg_d  = neg_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      neg_d  = dividend_i[SUM_W-1];
      quot_d = dividend_i[SUM_W-1] ? (~dividend_i + SUM_W'(1)) : dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      // one restoring step per cycle
      rem_d  = fits ? (rem_sh - {1'b0, div_q}) : rem_sh;
      quot_d = {quot_q[SUM_W-2:0], fits};
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(SUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = neg_q ? (~quot_q[VAL_W-1:0] + VAL_W'(1)) : quot_q[VAL_W-1:0];

endmodule
`default_nettype wire

// File: rtl/imu_offset_calibrator_unit.sv
// imu offset calibrator: a load word runs a write sweep over all six axes, a sample word
// a read and write-back of each sum; a sample that closes a window then runs the serial
// divider (one quotient bit a cycle) and the read/write-back of both rams for each axis
// sample words after both groups are done are dropped
// reset loads config defaults and clears flags and count, then a clearing pass zeroes
// the sums and offsets in both rams with the input held off
`default_nettype none
`include "imu_offset_calibrator_unit_assert.svh"
module imu_offset_calibrator_unit
  import imu_oc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_W-1:0]      cfg_wdata_i,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // val_ax, val_ay, val_az, val_gx, val_gy, val_gz
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // req_type
  input  wire logic                  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // accel_off_x, accel_off_y, accel_off_z, gyro_off_x, gyro_off_y, gyro_off_z,
  // accel_done, gyro_done, one zero pad bit
  output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_LOAD     = 3'd1;
  localparam logic [2:0] S_ACC_RD   = 3'd2;
  localparam logic [2:0] S_ACC_WR   = 3'd3;
  localparam logic [2:0] S_DIV_RD   = 3'd4;
  localparam logic [2:0] S_DIV_GO   = 3'd5;
  localparam logic [2:0] S_DIV_WAIT = 3'd6;
  localparam logic [2:0] S_UPD      = 3'd7;
  // finishing shares the update code space via a flag
  logic fin_q, fin_d;
  // clearing pass after reset shares the load sweep
  logic clr_q, clr_d;

  // configuration
  logic [SPW_W-1:0]  spw_q;
  logic [TOL_W-1:0]  acc_tol_q, gyr_tol_q;
  logic [GRAV_W-1:0] grav_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spw_q     <= SPW_RST;
      acc_tol_q <= ACC_TOL_RST;
      gyr_tol_q <= GYR_TOL_RST;
      grav_q    <= GRAVITY_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SPW:     spw_q     <= cfg_wdata_i[SPW_W-1:0];
        REG_ACC_TOL: acc_tol_q <= cfg_wdata_i[TOL_W-1:0];
        REG_GYR_TOL: gyr_tol_q <= cfg_wdata_i[TOL_W-1:0];
        REG_GRAVITY: grav_q    <= cfg_wdata_i[GRAV_W-1:0];
        default:     spw_q     <= spw_q;
      endcase
    end
  end

  // control state
  logic [2:0]            state_q, state_d;
  logic [AXIS_W-1:0]     idx_q, idx_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  accel_ok_q, accel_ok_d;
  logic                  gyro_ok_q, gyro_ok_d;
  logic [1:0]            grp_ok_q, grp_ok_d;
  logic                  out_valid_q, out_valid_d;

  // payload
  val_t       item_q [NUM_AXES];
  val_t       res_q  [NUM_AXES];
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  // state memories
  logic [SUM_W-1:0] sum_mem [NUM_AXES];
  val_t             off_mem [NUM_AXES];
  logic [SUM_W-1:0] sum_rd_q;
  val_t             off_rd_q;
  logic             sum_re, sum_we, off_re, off_we;
  logic [SUM_W-1:0] sum_wdata;
  val_t             off_wdata;

  always_ff @(posedge clk_i) begin
    if (sum_we) sum_mem[idx_q] <= sum_wdata;
    if (sum_re) sum_rd_q <= sum_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (off_we) off_mem[idx_q] <= off_wdata;
    if (off_re) off_rd_q <= off_mem[idx_q];
  end

  // divider
  logic      div_start;
  div_stat_t div_stat;
  val_t      div_quot;

  imu_oc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_rd_q),
    .divisor_i  (count_q),
    .stat_o     (div_stat),
    .quot_o     (div_quot)
  );

  // window bound: zero reads as one, clamped to the counter range
  logic [WIN_W-1:0]      spw_ext, cmax_ext, win;
  logic [COUNT_BITS-1:0] count_inc;
  logic                  s_acc;
  val_t                  cur_val, sample_off, mean, mag, new_off;
  logic                  is_accel, grp_done, below;
  logic [TOL_W-1:0]      tol;

  assign spw_ext   = WIN_W'(spw_q);
  assign cmax_ext  = WIN_W'({COUNT_BITS{1'b1}});
  assign win       = (spw_q == '0) ? WIN_W'(1) : ((spw_ext > cmax_ext) ? cmax_ext : spw_ext);
  assign count_inc = count_q + COUNT_BITS'(1);

  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign cur_val  = item_q[idx_q];
  assign is_accel = idx_q < AXIS_GX;
  assign grp_done = is_accel ? accel_ok_q : gyro_ok_q;
  assign tol      = is_accel ? acc_tol_q : gyr_tol_q;

  // mean of this axis, gravity removed from accel z
  assign mean    = (idx_q == AXIS_AZ) ? (div_quot - VAL_W'(grav_q)) : div_quot;
  assign mag     = mean[VAL_W-1] ? (~mean + VAL_W'(1)) : mean;
  assign below   = mag < VAL_W'(tol);
  assign new_off = grp_done ? off_rd_q : (off_rd_q - mean);
  assign sample_off = is_accel ? {cur_val[VAL_W-2:0], 1'b0} : cur_val;

  // accel offsets halved toward zero
  function automatic logic [ACC_OFF_W-1:0] half_tz(input val_t v);
    val_t t;
    begin
      t = v + VAL_W'(v[VAL_W-1]);
      half_tz = t[ACC_OFF_W:1];
    end
  endfunction

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    count_d     = count_q;
    accel_ok_d  = accel_ok_q;
    gyro_ok_d   = gyro_ok_q;
    grp_ok_d    = grp_ok_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    fin_d       = fin_q;
    clr_d       = clr_q;
    sum_re      = 1'b0;
    sum_we      = 1'b0;
    off_re      = 1'b0;
    off_we      = 1'b0;
    sum_wdata   = sum_rd_q + {{(SUM_W-VAL_W){cur_val[VAL_W-1]}}, cur_val};
    off_wdata   = new_off;
    div_start   = 1'b0;

    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        idx_d = '0;
        if (s_acc) begin
          if (s_axis_tuser == REQ_LOAD) begin
            state_d = S_LOAD;
          end else if (!(accel_ok_q && gyro_ok_q)) begin
            state_d = S_ACC_RD;
          end
        end
      end
      S_LOAD: begin
        sum_we    = 1'b1;
        sum_wdata = '0;
        off_we    = 1'b1;
        off_wdata = clr_q ? '0 : sample_off;
        idx_d     = idx_q + AXIS_W'(1);
        if (idx_q == AXIS_LAST) begin
          count_d    = '0;
          accel_ok_d = 1'b0;
          gyro_ok_d  = 1'b0;
          clr_d      = 1'b0;
          state_d    = S_IDLE;
        end
      end
      S_ACC_RD: begin
        sum_re  = 1'b1;
        state_d = S_ACC_WR;
      end
      S_ACC_WR: begin
        sum_we = 1'b1;
        if (idx_q == AXIS_LAST) begin
          count_d = count_inc;
          idx_d   = '0;
          if (WIN_W'(count_inc) >= win) begin
            grp_ok_d = 2'b11;
            state_d  = S_DIV_RD;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          idx_d   = idx_q + AXIS_W'(1);
          state_d = S_ACC_RD;
        end
      end
      S_DIV_RD: begin
        sum_re  = 1'b1;
        off_re  = 1'b1;
        state_d = S_DIV_GO;
      end
      S_DIV_GO: begin
        div_start = 1'b1;
        state_d   = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_stat.done) state_d = S_UPD;
      end
      S_UPD: begin
        if (!fin_q) begin
          sum_we    = 1'b1;
          sum_wdata = '0;
          off_we    = !grp_done;
          if (!below) begin
            if (is_accel) grp_ok_d[0] = 1'b0;
            else          grp_ok_d[1] = 1'b0;
          end
          if (idx_q == AXIS_LAST) begin
            fin_d = 1'b1;
          end else begin
            idx_d   = idx_q + AXIS_W'(1);
            state_d = S_DIV_RD;
          end
        end else if (!out_valid_q) begin
          // result slot free: publish and close the window
          accel_ok_d  = accel_ok_q | grp_ok_q[0];
          gyro_ok_d   = gyro_ok_q | grp_ok_q[1];
          count_d     = '0;
          fin_d       = 1'b0;
          out_valid_d = 1'b1;
          out_data_d  = {1'b0, gyro_ok_q | grp_ok_q[1], accel_ok_q | grp_ok_q[0],
                         res_q[5], res_q[4], res_q[3],
                         half_tz(res_q[2]), half_tz(res_q[1]), half_tz(res_q[0])};
          idx_d       = '0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      idx_q       <= '0;
      count_q     <= '0;
      accel_ok_q  <= 1'b0;
      gyro_ok_q   <= 1'b0;
      grp_ok_q    <= 2'b11;
      out_valid_q <= 1'b0;
      fin_q       <= 1'b0;
      clr_q       <= 1'b1;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      accel_ok_q  <= accel_ok_d;
      gyro_ok_q   <= gyro_ok_d;
      grp_ok_q    <= grp_ok_d;
      out_valid_q <= out_valid_d;
      fin_q       <= fin_d;
      clr_q       <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (s_acc) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        item_q[i] <= s_axis_tdata[i*VAL_W +: VAL_W];
      end
    end
    if (state_q == S_UPD && !fin_q) res_q[idx_q] <= new_off;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `IOC_ASSERT_NOW(a_div_done_in_wait, div_stat.done, state_q == S_DIV_WAIT,
    "divider finished outside its wait state")
  `IOC_ASSERT_NOW(a_no_acc_when_done, state_q == S_ACC_RD, !(accel_ok_q && gyro_ok_q),
    "summing a sample after both groups are done")
  `IOC_ASSERT_NEXT(a_result_from_fin, !out_valid_q && !(state_q == S_UPD && fin_q),
    !out_valid_q, "result word appeared without finishing a window")
  `IOC_ASSERT_NOW(a_div_idle_on_start, div_start, !div_stat.busy,
    "divider restarted while busy")

endmodule
`default_nettype wire
